>>> sv/rmq_pkg.sv
package rmq_pkg;

  localparam int unsigned DataWidthDef = 16;
  localparam int unsigned FracBitsDef  = 14;

  // fixed field widths of the transactions
  localparam int unsigned FW = 16;

  localparam logic [1:0] CaseTrace = 2'd0;
  localparam logic [1:0] CaseX     = 2'd1;
  localparam logic [1:0] CaseY     = 2'd2;
  localparam logic [1:0] CaseZ     = 2'd3;

  typedef struct packed {
    logic signed [FW-1:0] m00;
    logic signed [FW-1:0] m01;
    logic signed [FW-1:0] m02;
    logic signed [FW-1:0] m10;
    logic signed [FW-1:0] m11;
    logic signed [FW-1:0] m12;
    logic signed [FW-1:0] m20;
    logic signed [FW-1:0] m21;
    logic signed [FW-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [FW-1:0] qw;
    logic signed [FW-1:0] qx;
    logic signed [FW-1:0] qy;
    logic signed [FW-1:0] qz;
    logic [1:0]           case_used;
    logic                 divide_fault;
  } out_t;

  // classified work item between front and back: radicand and numerators
  // radicand < 2^(FW+2), numerators fit FW+1 bits signed
  typedef struct packed {
    logic [FW+1:0]        rad;
    logic signed [FW:0]   n0;
    logic signed [FW:0]   n1;
    logic signed [FW:0]   n2;
    logic signed [FW:0]   n3;
    logic [1:0]           sel;
  } work_t;

endpackage

>>> sv/rmq_front.sv
module rmq_front
  import rmq_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_i,
  output logic  wk_valid_o,
  input  logic  wk_ready_i,
  output work_t wk_o
);

  localparam int unsigned SW = FW + 3;

  logic signed [SW-1:0] a, b, c, tr, one_s, t;
  logic signed [FW:0]   d21, d02, d10, s02, s01, s12;
  work_t                w;
  logic                 valid_q;
  work_t                wk_q;

  assign a     = SW'(in_i.m00);
  assign b     = SW'(in_i.m11);
  assign c     = SW'(in_i.m22);
  assign tr    = a + b + c;
  assign one_s = SW'(1) <<< FracBits;
  assign d21   = (FW+1)'(in_i.m21) - (FW+1)'(in_i.m12);
  assign d02   = (FW+1)'(in_i.m02) - (FW+1)'(in_i.m20);
  assign d10   = (FW+1)'(in_i.m10) - (FW+1)'(in_i.m01);
  assign s02   = (FW+1)'(in_i.m02) + (FW+1)'(in_i.m20);
  assign s01   = (FW+1)'(in_i.m01) + (FW+1)'(in_i.m10);
  assign s12   = (FW+1)'(in_i.m12) + (FW+1)'(in_i.m21);

  always_comb begin
    w = '0;
    if (tr > 0) begin
      w.sel = CaseTrace;
      t = one_s + tr;
      w.n1 = d21; w.n2 = d02; w.n3 = d10;
    end else if (a > b && a > c) begin
      w.sel = CaseX;
      t = one_s + a - b - c;
      w.n0 = d21; w.n2 = s01; w.n3 = s02;
    end else if (b > c) begin
      w.sel = CaseY;
      t = one_s + b - a - c;
      w.n0 = d02; w.n1 = s01; w.n3 = s12;
    end else begin
      w.sel = CaseZ;
      t = one_s + c - a - b;
      w.n0 = d10; w.n1 = s02; w.n2 = s12;
    end
    // negative radicand counts as zero
    w.rad = t[SW-1] ? '0 : t[FW+1:0];
  end

  assign in_ready_o = !valid_q || wk_ready_i;
  assign wk_valid_o = valid_q;
  assign wk_o       = wk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      wk_q <= w;
    end
  end

endmodule

>>> sv/rmq_fifo.sv
module rmq_fifo
  import rmq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  work_t wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output work_t rd_data_o
);

  work_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

>>> sv/rmq_back.sv
module rmq_back
  import rmq_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wk_valid_i,
  output logic  wk_ready_o,
  input  work_t wk_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output out_t  out_o
);

  // root stages: radicand << FracBits, RW bits, one root bit per stage
  localparam int unsigned RW  = FW + 2 + FracBits;
  localparam int unsigned RB  = (RW + 1) / 2;
  // divider: |n| << FracBits over 2r, one quotient bit per stage
  localparam int unsigned NW  = FW + 1 + FracBits;
  localparam int unsigned DW  = RB + 1;
  localparam int unsigned NS  = RB + NW;
  localparam int unsigned QMAX = (1 << (FW-1)) - 1;

  typedef struct packed {
    logic [2*RB-1:0]  rem;
    logic [RB-1:0]    root;
    logic [2*RB-1:0]  v;
    logic [3:0][NW-1:0] mag;
    logic [3:0]       neg;
    logic [1:0]       sel;
  } rstg_t;

  typedef struct packed {
    logic [3:0][NW-1:0] quo;
    logic [3:0][DW-1:0] rem;
    logic [DW-1:0]      den;
    logic [RB-1:0]      root;
    logic [3:0]         neg;
    logic [1:0]         sel;
  } dstg_t;

  rstg_t      rs_in;
  rstg_t      rs_q [1:RB];
  dstg_t      ds_in;
  dstg_t      ds_q [1:NW];
  logic [NS-1:0] vld_q;
  logic        adv;
  out_t        res;
  out_t        ob_q, sk_q;
  logic        ob_v_q, sk_v_q;
  logic [3:0][FW:0] nn;

  assign nn = {wk_i.n3, wk_i.n2, wk_i.n1, wk_i.n0};
  // pipeline moves whenever the tail slot is free
  assign adv        = !sk_v_q;
  assign wk_ready_o = adv;

  always_comb begin
    rs_in = '0;
    rs_in.v = (2*RB)'({wk_i.rad, {FracBits{1'b0}}});
    rs_in.sel = wk_i.sel;
    for (int k = 0; k < 4; k++) begin
      rs_in.neg[3-k] = nn[k][FW];
      rs_in.mag[3-k] = NW'(nn[k][FW] ? -nn[k] : nn[k]) << FracBits;
    end
  end

  // restoring square root, two radicand bits per stage
  for (genvar s = 0; s < RB; s++) begin : g_root
    rstg_t cur, nx;
    if (s == 0) begin : g_src
      assign cur = rs_in;
    end else begin : g_src
      assign cur = rs_q[s];
    end
    always_comb begin
      logic [2*RB-1:0] trial;
      nx      = cur;
      nx.rem  = {cur.rem[2*RB-3:0], cur.v[2*RB-1 -: 2]};
      trial   = (2*RB)'({cur.root, 2'b01});
      nx.root = {cur.root[RB-2:0], 1'b0};
      if (nx.rem >= trial) begin
        nx.rem     = nx.rem - trial;
        nx.root[0] = 1'b1;
      end
      nx.v = {cur.v[2*RB-3:0], 2'b00};
    end
    always_ff @(posedge clk_i) begin
      if (adv) rs_q[s+1] <= nx;
    end
  end

  always_comb begin
    ds_in      = '0;
    ds_in.den  = {rs_q[RB].root, 1'b0};
    ds_in.root = rs_q[RB].root;
    ds_in.neg  = rs_q[RB].neg;
    ds_in.sel  = rs_q[RB].sel;
    ds_in.quo  = rs_q[RB].mag;
  end

  // four restoring dividers in lockstep, one quotient bit per stage
  for (genvar s = 0; s < NW; s++) begin : g_div
    dstg_t cur, nx;
    if (s == 0) begin : g_src
      assign cur = ds_in;
    end else begin : g_src
      assign cur = ds_q[s];
    end
    always_comb begin
      nx = cur;
      for (int k = 0; k < 4; k++) begin
        logic [DW:0] tr;
        tr = {cur.rem[k], cur.quo[k][NW-1]};
        nx.quo[k] = {cur.quo[k][NW-2:0], 1'b0};
        if (tr >= {1'b0, cur.den}) begin
          tr = tr - {1'b0, cur.den};
          nx.quo[k][0] = 1'b1;
        end
        nx.rem[k] = tr[DW-1:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) ds_q[s+1] <= nx;
    end
  end

  always_comb begin
    logic [NW:0] mq;
    logic [RB-1:0] h;
    res = '0;
    res.case_used = ds_q[NW].sel;
    res.divide_fault = ds_q[NW].root == '0;
    h = ds_q[NW].root >> 1;
    for (int k = 0; k < 4; k++) begin
      logic signed [FW-1:0] q;
      if (k == int'(ds_q[NW].sel)) begin
        q = (h > RB'(QMAX)) ? FW'(QMAX) : FW'(h);
      end else begin
        mq = {1'b0, ds_q[NW].quo[3-k]};
        if (ds_q[NW].neg[3-k]) begin
          q = (mq > (NW+1)'(QMAX+1)) ? FW'(QMAX+1) : FW'(-mq);
        end else begin
          q = (mq > (NW+1)'(QMAX)) ? FW'(QMAX) : FW'(mq);
        end
      end
      if (res.divide_fault) q = '0;
      case (k)
        0: res.qw = q;
        1: res.qx = q;
        2: res.qy = q;
        default: res.qz = q;
      endcase
    end
  end

  // output register plus skid slot
  assign out_valid_o = ob_v_q;
  assign out_o       = ob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      ob_v_q <= 1'b0;
      sk_v_q <= 1'b0;
    end else begin
      if (adv) vld_q <= {vld_q[NS-2:0], wk_valid_i};
      if (!ob_v_q || out_ready_i) begin
        ob_v_q <= sk_v_q || (adv && vld_q[NS-1]);
        sk_v_q <= 1'b0;
      end else if (adv && vld_q[NS-1]) begin
        sk_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ob_v_q || out_ready_i) begin
      ob_q <= sk_v_q ? sk_q : res;
    end else if (adv && vld_q[NS-1]) begin
      sk_q <= res;
    end
  end

endmodule

>>> sv/rotation_matrix_to_quaternion.sv
// channel | valid      | ready      | payload
// input   | in_valid_i | in_ready_o | in_i  (rmq_pkg::in_t)
// output  | out_valid_o| out_ready_i| out_o (rmq_pkg::out_t)
//
// one matrix per cycle sustained while the output is not stalled; at the
// default widths a result passes the front register, the queue, 16 root
// stages (one per root bit), 31 divide stages (one per quotient bit) and
// the output register
// reset clears all valid flags, no clearing pass
// a stall at the output freezes the back pipeline once the skid slot fills,
// until the skid slot empties again; the two-entry queue and the front register
// keep accepting up to three transactions while the back is held
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic  fv, fr, qv, qr;
  work_t fw, qw;

  // front: case selection, radicand and numerators
  rmq_front #(.FracBits(FracBits)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i,
    .wk_valid_o(fv), .wk_ready_i(fr), .wk_o(fw)
  );

  // short decoupling queue
  rmq_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fw),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qw)
  );

  // back: pipelined root, dividers, saturation
  rmq_back #(.FracBits(FracBits)) u_back (
    .clk_i, .rst_ni, .wk_valid_i(qv), .wk_ready_o(qr), .wk_i(qw),
    .out_valid_o, .out_ready_i, .out_o
  );

endmodule

>>> sv/rmq_checker.sv
module rmq_checker
  import rmq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_o
);

  // a waiting input transaction stays offered
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input withdrawn while waiting");

  // a held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  // fault forces zero components
  a_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.divide_fault |->
      out_o.qw == 0 && out_o.qx == 0 && out_o.qy == 0 && out_o.qz == 0)
    else $error("fault with nonzero result");

  // root component qw never negative in the trace case
  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.case_used == CaseTrace |-> !out_o.qw[FW-1])
    else $error("negative root component");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_o
);
